// File: rtl/core/cpfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV price field parser package
// Field limits, character codes and widths shared by the parser and its
// channel interfaces.
// ----------------------------------------------------------------------------
package cpfp_pkg;

  localparam int MAX_FIELD_CHARS = 16;
  localparam int MAX_INT_DIGITS  = 9;
  localparam int NUM_FIELDS      = 5;

  localparam int BYTE_W    = 8;
  localparam int INDEX_W   = 3;
  localparam int VALUE_W   = 37;
  localparam int COMMA_W   = 3;
  localparam int INT_CNT_W = 4;
  localparam int FRAC_W    = 2;
  localparam int LEN_W     = 5;

  localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CHAR_POINT = 8'h2E;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

  localparam logic [COMMA_W-1:0] COMMA_MAX  = '1;
  localparam logic [FRAC_W-1:0]  FRAC_KEEP  = 2'd2;

  localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

  typedef logic [VALUE_W-1:0] value_t;

endpackage

// File: rtl/core/cpfp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV price field parser channels
// Valid/ready channels for input characters and parsed field results.
// ----------------------------------------------------------------------------
interface cpfp_in_if
  import cpfp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              end_of_line;

  modport source (output valid, output data_byte, output end_of_line, input ready);
  modport sink   (input valid, input data_byte, input end_of_line, output ready);
endinterface

interface cpfp_out_if
  import cpfp_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] field_index;
  logic [VALUE_W-1:0] price_value;
  logic               error;

  modport source (output valid, output field_index, output price_value, output error,
                  input ready);
  modport sink   (input valid, input field_index, input price_value, input error,
                  output ready);
endinterface

// File: rtl/core/csv_price_field_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV price field parser
// Parses the five price fields of a quote line into values in hundredths.
// ----------------------------------------------------------------------------
// One character beat is taken per clock whenever the result register is empty
// or is being drained in the same cycle, so a steady stream runs at one byte
// per cycle. The field state is updated in the cycle a beat is taken, and the
// result for a field is in the output register in the cycle after its closing
// comma is taken. Fields between the first and sixth commas are reported as
// open, previous close, close, high and low; errored fields read as zero.
module csv_price_field_parser_top
  import cpfp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  cpfp_in_if.sink       in_ch,
  cpfp_out_if.source    out_ch
);

  logic [COMMA_W-1:0]   comma_count, comma_count_next;
  value_t               accumulator, accumulator_next;
  logic [INT_CNT_W-1:0] integer_digits, integer_digits_next;
  logic [FRAC_W-1:0]    fraction_digits, fraction_digits_next;
  logic                 seen_point, seen_point_next;
  logic [LEN_W-1:0]     field_length, field_length_next;
  logic                 field_bad, field_bad_next;

  logic                 out_valid;
  logic [INDEX_W-1:0]   out_index;
  value_t               out_value;
  logic                 out_error;

  logic                 accept;
  logic                 in_field;
  logic                 is_digit;
  logic [VALUE_W+3:0]   pushed;
  logic [VALUE_W+6:0]   scaled;
  logic                 emit;
  logic                 emit_error;
  value_t               emit_value;
  logic [INDEX_W-1:0]   emit_index;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign in_field = (comma_count >= COMMA_W'(1)) && (comma_count <= COMMA_W'(NUM_FIELDS));
  assign is_digit = (in_ch.data_byte >= CHAR_ZERO) && (in_ch.data_byte <= CHAR_NINE);

  // Accumulator times ten plus the new digit.
  assign pushed = {1'b0, accumulator, 3'b000} + {3'b000, accumulator, 1'b0}
                + {{(VALUE_W){1'b0}}, in_ch.data_byte[3:0]};

  always_comb begin
    unique case (fraction_digits)
      2'd0:    scaled = {1'b0, accumulator, 6'b0} + {2'b0, accumulator, 5'b0}
                      + {5'b0, accumulator, 2'b0};
      2'd1:    scaled = {4'b0, accumulator, 3'b0} + {6'b0, accumulator, 1'b0};
      default: scaled = {7'b0, accumulator};
    endcase
  end

  always_comb begin
    emit_error = field_bad || (field_length == '0) || (scaled > {7'b0, VALUE_MAX});
    emit_value = emit_error ? '0 : scaled[VALUE_W-1:0];
    emit_index = INDEX_W'(comma_count - COMMA_W'(1));
  end

  always_comb begin
    comma_count_next     = comma_count;
    accumulator_next     = accumulator;
    integer_digits_next  = integer_digits;
    fraction_digits_next = fraction_digits;
    seen_point_next      = seen_point;
    field_length_next    = field_length;
    field_bad_next       = field_bad;
    emit                 = 1'b0;

    if (in_ch.data_byte == CHAR_COMMA) begin
      emit = in_field;
      if (comma_count != COMMA_MAX) begin
        comma_count_next = comma_count + COMMA_W'(1);
      end
      accumulator_next     = '0;
      integer_digits_next  = '0;
      fraction_digits_next = '0;
      seen_point_next      = 1'b0;
      field_length_next    = '0;
      field_bad_next       = 1'b0;
    end else if (in_field) begin
      if (field_length >= LEN_W'(MAX_FIELD_CHARS)) begin
        field_bad_next = 1'b1;
      end else begin
        field_length_next = field_length + LEN_W'(1);
      end
      if (is_digit) begin
        if (!seen_point) begin
          if (integer_digits >= INT_CNT_W'(MAX_INT_DIGITS)) begin
            field_bad_next = 1'b1;
          end else begin
            integer_digits_next = integer_digits + INT_CNT_W'(1);
            if (pushed > {4'b0, VALUE_MAX}) begin
              field_bad_next = 1'b1;
            end else begin
              accumulator_next = pushed[VALUE_W-1:0];
            end
          end
        end else if (fraction_digits < FRAC_KEEP) begin
          fraction_digits_next = fraction_digits + FRAC_W'(1);
          if (pushed > {4'b0, VALUE_MAX}) begin
            field_bad_next = 1'b1;
          end else begin
            accumulator_next = pushed[VALUE_W-1:0];
          end
        end
      end else if (in_ch.data_byte == CHAR_POINT) begin
        if (seen_point) begin
          field_bad_next = 1'b1;
        end
        seen_point_next = 1'b1;
      end else begin
        field_bad_next = 1'b1;
      end
    end

    if (in_ch.end_of_line) begin
      comma_count_next     = '0;
      accumulator_next     = '0;
      integer_digits_next  = '0;
      fraction_digits_next = '0;
      seen_point_next      = 1'b0;
      field_length_next    = '0;
      field_bad_next       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      comma_count     <= '0;
      accumulator     <= '0;
      integer_digits  <= '0;
      fraction_digits <= '0;
      seen_point      <= 1'b0;
      field_length    <= '0;
      field_bad       <= 1'b0;
    end else if (accept) begin
      comma_count     <= comma_count_next;
      accumulator     <= accumulator_next;
      integer_digits  <= integer_digits_next;
      fraction_digits <= fraction_digits_next;
      seen_point      <= seen_point_next;
      field_length    <= field_length_next;
      field_bad       <= field_bad_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_index <= emit_index;
      out_value <= emit_value;
      out_error <= emit_error;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.field_index = out_index;
  assign out_ch.price_value = out_value;
  assign out_ch.error       = out_error;

endmodule

// File: tb/csv_price_field_parser_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV price field parser regression
// Streams quote lines one character per beat into the parser and checks every
// field result against a predictor of the parser kept in step with the
// accepted input, or against the hand-built result that a table line gives.
// A short table of hand-built lines opens the run, then random quote lines,
// broken lines and noise, random gaps on both channels and one long result stall.
// ----------------------------------------------------------------------------
module csv_price_field_parser_top_test;
  import cpfp_pkg::*;

  typedef logic [BYTE_W-1:0] char_t;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    value_t             value;
    logic               error;
  } field_result_t;

  typedef struct {
    string         text;
    char_t         raw;
    bit            eol;
    bit            typed;
    field_result_t want;
  } quote_row_t;

  localparam int TOTAL_BEATS  = 450;
  localparam int HOLD_CYCLES  = 64;
  localparam int STALL_LIMIT  = 1000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cpfp_in_if  in_ch();
  cpfp_out_if out_ch();

  csv_price_field_parser_top dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  logic [COMMA_W-1:0]   commas_seen;
  value_t               price_acc;
  logic [INT_CNT_W-1:0] int_digit_count;
  logic [FRAC_W-1:0]    frac_digit_count;
  bit                   point_seen;
  logic [LEN_W-1:0]     chars_in_field;
  bit                   field_broken;

  field_result_t pending_fields[$];
  char_t         line_bytes[$];

  int  mismatch_count = 0;
  int  fields_checked = 0;
  int  fields_errored = 0;
  int  bytes_used     = 0;
  int  beats_sent     = 0;
  int  lines_sent     = 0;
  int  stall_cycles   = 0;
  bit  send_gaps      = 1'b1;
  bit  take_gaps      = 1'b1;
  bit  hold_results   = 1'b0;

  quote_row_t quote_rows [16] = '{
    '{"",                   8'h00, 1'b0, 1'b0, '0},
    '{"AB,",                8'h00, 1'b0, 1'b0, '0},
    '{",",                  8'h00, 1'b0, 1'b1, {3'd0, 37'd0, 1'b1}},
    '{"999999999.99,",      8'h00, 1'b0, 1'b1, {3'd1, 37'd99999999999, 1'b0}},
    '{".5,",                8'h00, 1'b0, 1'b1, {3'd2, 37'd50, 1'b0}},
    '{".,",                 8'h00, 1'b0, 1'b1, {3'd3, 37'd0, 1'b0}},
    '{"1.2.,",              8'h00, 1'b0, 1'b1, {3'd4, 37'd0, 1'b1}},
    '{"9,,,,x",             8'h00, 1'b1, 1'b0, '0},
    '{",0123456789,",       8'h00, 1'b0, 1'b1, {3'd0, 37'd0, 1'b1}},
    '{"1234567.12345678,",  8'h00, 1'b0, 1'b0, '0},
    '{"0.000000000000000,", 8'h00, 1'b0, 1'b1, {3'd2, 37'd0, 1'b1}},
    '{"7",                  8'h00, 1'b0, 1'b0, '0},
    '{"",                   8'hFF, 1'b0, 1'b0, '0},
    '{",",                  8'h00, 1'b0, 1'b1, {3'd3, 37'd0, 1'b1}},
    '{"3.1",                8'h00, 1'b1, 1'b0, '0},
    '{"Q,8,",               8'h00, 1'b1, 1'b1, {3'd0, 37'd800, 1'b0}}
  };

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $realtime, what);
    mismatch_count++;
  endtask

  function automatic void clear_field_state();
    price_acc        = '0;
    int_digit_count  = '0;
    frac_digit_count = '0;
    point_seen       = 1'b0;
    chars_in_field   = '0;
    field_broken     = 1'b0;
  endfunction

  function automatic void append_digit(input char_t ch);
    logic [63:0] grown;
    grown = 64'(price_acc) * 64'd10 + 64'(ch - CHAR_ZERO);
    if (grown > 64'(VALUE_MAX)) begin
      field_broken = 1'b1;
    end else begin
      price_acc = grown[VALUE_W-1:0];
    end
  endfunction

  task automatic predict_field(input char_t ch, input bit eol, output bit used,
                               output bit emits, output field_result_t res);
    logic [63:0] scaled;
    bit          bad;
    used  = 1'b0;
    emits = 1'b0;
    res   = '0;
    if (ch == CHAR_COMMA) begin
      used = 1'b1;
      if (commas_seen >= 1 && commas_seen <= NUM_FIELDS) begin
        bad    = field_broken || chars_in_field == 0;
        scaled = 64'(price_acc);
        for (int k = int'(frac_digit_count); k < int'(FRAC_KEEP) && !bad; k++) begin
          scaled = scaled * 64'd10;
          if (scaled > 64'(VALUE_MAX)) bad = 1'b1;
        end
        res.index = INDEX_W'(commas_seen - 1);
        res.value = bad ? '0 : scaled[VALUE_W-1:0];
        res.error = bad;
        emits     = 1'b1;
      end
      if (commas_seen < COMMA_MAX) commas_seen++;
      clear_field_state();
    end else if (commas_seen >= 1 && commas_seen <= NUM_FIELDS) begin
      used = 1'b1;
      if (chars_in_field >= MAX_FIELD_CHARS) begin
        field_broken = 1'b1;
      end else begin
        chars_in_field++;
      end
      if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
        if (!point_seen) begin
          if (int_digit_count >= MAX_INT_DIGITS) begin
            field_broken = 1'b1;
          end else begin
            int_digit_count++;
            append_digit(ch);
          end
        end else if (frac_digit_count < FRAC_KEEP) begin
          frac_digit_count++;
          append_digit(ch);
        end
      end else if (ch == CHAR_POINT) begin
        if (point_seen) field_broken = 1'b1;
        point_seen = 1'b1;
      end else begin
        field_broken = 1'b1;
      end
    end
    if (eol) begin
      commas_seen = '0;
      clear_field_state();
    end
  endtask

  task automatic send_beat(input char_t ch, input bit eol, input bit typed,
                           input field_result_t want);
    bit            used;
    bit            emits;
    field_result_t res;
    @(negedge clk);
    while (send_gaps && $urandom_range(0, 99) < 37) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= ch;
    in_ch.end_of_line <= eol;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
    predict_field(ch, eol, used, emits, res);
    if (used) bytes_used++;
    if (typed) begin
      pending_fields.push_back(want);
    end else if (emits) begin
      pending_fields.push_back(res);
    end
  endtask

  function automatic void push_digits(input int count);
    repeat (count) line_bytes.push_back(CHAR_ZERO + char_t'($urandom_range(0, 9)));
  endfunction

  function automatic char_t random_stray();
    char_t b;
    do begin
      b = char_t'($urandom_range(0, 255));
    end while (b == CHAR_COMMA || b == CHAR_POINT || (b >= CHAR_ZERO && b <= CHAR_NINE));
    return b;
  endfunction

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  always @(posedge clk) begin
    field_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_fields.size() == 0) begin
        report_mismatch($sformatf("unexpected result index %0d value %0d error %0b",
                                  out_ch.field_index, out_ch.price_value, out_ch.error));
      end else begin
        want = pending_fields.pop_front();
        fields_checked++;
        if (want.error) fields_errored++;
        if (out_ch.field_index !== want.index) begin
          report_mismatch($sformatf("field_index %0d, expected %0d",
                                    out_ch.field_index, want.index));
        end
        if (out_ch.price_value !== want.value) begin
          report_mismatch($sformatf("price_value %0d, expected %0d (index %0d)",
                                    out_ch.price_value, want.value, want.index));
        end
        if (out_ch.error !== want.error) begin
          report_mismatch($sformatf("error %0b, expected %0b (index %0d)",
                                    out_ch.error, want.error, want.index));
        end
      end
    end
  end

  initial begin
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (hold_results) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_results = 1'b0;
      end
      out_ch.ready <= take_gaps ? ($urandom_range(0, 99) >= 37) : 1'b1;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
    $display("csv_price_field_parser_top regression: fail");
    $finish;
  end

  initial begin
    int    base_beats;
    int    kind;
    int    n_int;
    int    n_frac;
    int    n_fields;
    int    cut;
    bit    pressure_done;
    string text;
    in_ch.valid       = 1'b0;
    in_ch.data_byte   = '0;
    in_ch.end_of_line = 1'b0;
    out_ch.ready      = 1'b0;
    pressure_done     = 1'b0;
    commas_seen       = '0;
    clear_field_state();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (quote_rows[r]) begin
      text = quote_rows[r].text;
      if (text.len() == 0) begin
        send_beat(quote_rows[r].raw, quote_rows[r].eol, quote_rows[r].typed,
                  quote_rows[r].want);
      end else begin
        for (int i = 0; i < text.len(); i++) begin
          send_beat(char_t'(text[i]), quote_rows[r].eol && i == text.len() - 1,
                    quote_rows[r].typed && i == text.len() - 1, quote_rows[r].want);
        end
      end
    end

    base_beats = beats_sent;
    while (beats_sent < TOTAL_BEATS) begin
      line_bytes.delete();
      take_gaps = !(beats_sent >= base_beats + 120 && beats_sent < base_beats + 220);
      send_gaps = take_gaps;
      if (!pressure_done && beats_sent >= base_beats + 300) begin
        pressure_done = 1'b1;
        hold_results  = 1'b1;
        send_gaps     = 1'b0;
      end
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(5, 20)) line_bytes.push_back(char_t'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(0, 3)) line_bytes.push_back(char_t'($urandom_range(8'h41, 8'h5A)));
        line_bytes.push_back(CHAR_COMMA);
        n_fields = ($urandom_range(0, 99) < 85) ? NUM_FIELDS : $urandom_range(0, 7);
        repeat (n_fields) begin
          kind = $urandom_range(0, 99);
          if (kind < 70 || kind >= 88) begin
            n_int = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_INT_DIGITS)
                                                : $urandom_range(1, 4);
            push_digits(n_int);
            if ($urandom_range(0, 99) < 60) begin
              line_bytes.push_back(CHAR_POINT);
              push_digits($urandom_range(0, 4));
            end
            if (kind >= 94) begin
              line_bytes.push_back(CHAR_POINT);
              push_digits($urandom_range(0, 2));
            end else if (kind >= 88) begin
              line_bytes.insert($urandom_range(line_bytes.size() - n_int, line_bytes.size()),
                                random_stray());
            end
          end else if (kind < 82 && kind >= 76) begin
            push_digits($urandom_range(MAX_INT_DIGITS + 1, MAX_INT_DIGITS + 3));
          end else if (kind >= 82) begin
            n_int = $urandom_range(1, 8);
            push_digits(n_int);
            line_bytes.push_back(CHAR_POINT);
            n_frac = MAX_FIELD_CHARS - n_int + $urandom_range(0, 3);
            push_digits(n_frac);
          end
          line_bytes.push_back(CHAR_COMMA);
        end
        repeat ($urandom_range(0, 3)) begin
          line_bytes.push_back(($urandom_range(0, 3) == 0) ? CHAR_COMMA
                                                            : char_t'($urandom_range(8'h30, 8'h5A)));
        end
        if ($urandom_range(0, 9) == 0 && line_bytes.size() > 1) begin
          cut = $urandom_range(1, line_bytes.size() - 1);
          while (line_bytes.size() > cut) void'(line_bytes.pop_back());
        end
      end
      foreach (line_bytes[i]) begin
        send_beat(line_bytes[i], i == line_bytes.size() - 1, 1'b0, '0);
      end
      lines_sent++;
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_fields.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d beats in %0d random lines; %0d bytes reached the field logic.",
             beats_sent, lines_sent, bytes_used);
    $display("Checked %0d field results, %0d of them flagged as errors.",
             fields_checked, fields_errored);
    if (mismatch_count == 0) begin
      $display("csv_price_field_parser_top regression: pass");
    end else begin
      $display("csv_price_field_parser_top regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/cpfp_pkg.sv
rtl/core/cpfp_if.sv
rtl/core/csv_price_field_parser_top.sv
tb/csv_price_field_parser_top_test.sv
